### rtl/core/lmcr_pkg.sv
// Shared types, codes and helper functions for the LED matrix chain refresh unit.
// No dependencies; used by lmcr_store, lmcr_seq and led_matrix_chain_refresh_unit.
`timescale 1ns / 1ps

package lmcr_pkg;

    // Frame store geometry: one byte per chip row, 64 bytes
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;

    // Largest chip count the chain supports
    localparam int MAX_DEVICES_DEFAULT = 8;

    // Leftmost pixel of a byte
    localparam logic [7:0] BIT_MSB = 8'h80;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_SET     = 2'd0,
        OP_REFRESH = 2'd1,
        OP_BCAST   = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    // Orientation codes
    localparam logic [1:0] ORIENT_NORMAL      = 2'd0;
    localparam logic [1:0] ORIENT_UPSIDE_DOWN = 2'd1;
    localparam logic [1:0] ORIENT_TURN_RIGHT  = 2'd2;
    localparam logic [1:0] ORIENT_TURN_LEFT   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_ACROSS = 2'd0;
    localparam logic [1:0] CFG_DOWN   = 2'd1;
    localparam logic [1:0] CFG_ORIENT = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SET_WR,
        ST_RUN,
        ST_DRAIN
    } seq_state_t;

    // Effective grid after clamping
    typedef struct packed {
        logic [3:0] across;
        logic [3:0] down;
        logic [3:0] count;
    } grid_t;

    // Description of one word on its way to the output
    typedef struct packed {
        logic       use_mem;
        logic       mirror;
        logic [7:0] const_byte;
        logic [3:0] opcode;
        logic       latch;
        logic       last;
    } word_meta_t;

    typedef struct packed {
        logic       valid;
        word_meta_t meta;
    } issue_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } rd_req_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wr_req_t;

    // Reverse the bit order of a byte
    function automatic logic [7:0] mirror8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = b[i];
        end
        return r;
    endfunction

    // Clamp the configured grid to the chain length
    function automatic grid_t grid_size(input logic [3:0] across_cfg,
                                        input logic [3:0] down_cfg,
                                        input logic [3:0] max_dev);
        logic [3:0] a;
        logic [3:0] d;
        logic [7:0] prod;
        logic [7:0] trial;
        grid_t      g;
        a    = (across_cfg == 4'd0) ? 4'd1 : across_cfg;
        d    = (down_cfg == 4'd0) ? 4'd1 : down_cfg;
        prod = {4'd0, a} * {4'd0, d};
        if (prod > {4'd0, max_dev}) begin
            if (a >= max_dev) begin
                a = max_dev;
                d = 4'd1;
            end
            else begin
                // largest row count that still fits the chain
                d = 4'd1;
                for (int i = 1; i <= 8; i++) begin
                    trial = 8'(i) * {4'd0, a};
                    if (trial <= {4'd0, max_dev}) begin
                        d = 4'(i);
                    end
                end
            end
        end
        prod     = {4'd0, a} * {4'd0, d};
        g.across = a;
        g.down   = d;
        g.count  = prod[3:0];
        return g;
    endfunction

endpackage

### rtl/core/lmcr_store.sv
// Frame store: 64-byte synchronous memory with one registered read port.
// Per-entry valid bits give all-zero contents after reset and clear.
// Depends on lmcr_pkg.
`timescale 1ns / 1ps

module lmcr_store
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     clear,
    input  lmcr_pkg::rd_req_t        rd_req,
    input  lmcr_pkg::wr_req_t        wr_req,
    output logic [7:0]               rd_data
);

    logic [7:0]                      mem [lmcr_pkg::STORE_DEPTH];
    logic [lmcr_pkg::STORE_DEPTH-1:0] valid_reg;
    logic [7:0]                      rd_data_reg;
    logic                            rd_valid_reg;

    // Write the memory array
    always_ff @(posedge clk)
    begin
        if (wr_req.en) begin
            mem[wr_req.addr] <= wr_req.data;
        end
    end

    // Read the memory array into the output register
    always_ff @(posedge clk)
    begin
        if (rd_req.en) begin
            rd_data_reg <= mem[rd_req.addr];
        end
    end

    // Track written entries; clear drops them all at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else begin
            if (clear) begin
                valid_reg <= '0;
            end
            else if (wr_req.en) begin
                valid_reg[wr_req.addr] <= 1'b1;
            end
            if (rd_req.en) begin
                rd_valid_reg <= valid_reg[rd_req.addr];
            end
        end
    end

    // Unwritten entries read as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : 8'd0;

endmodule

### rtl/core/lmcr_seq.sv
// Item sequencer: takes items, does the set-pixel read-modify-write and
// walks frames and chips for refresh, broadcast and clear. Depends on lmcr_pkg.
`timescale 1ns / 1ps

module lmcr_seq
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [1:0]                    operation,
    input  logic [5:0]                    pixel_x,
    input  logic [5:0]                    pixel_y,
    input  logic                          pixel_on,
    input  logic [3:0]                    reg_opcode,
    input  logic [7:0]                    reg_value,
    input  lmcr_pkg::grid_t               grid,
    input  logic [1:0]                    orientation,
    input  logic                          adv,
    input  logic                          out_done,
    input  logic [7:0]                    rd_data,
    output logic                          busy,
    output logic                          clear,
    output lmcr_pkg::rd_req_t             rd_req,
    output lmcr_pkg::wr_req_t             wr_req,
    output lmcr_pkg::issue_t              issue
);

    lmcr_pkg::seq_state_t         state_reg;
    lmcr_pkg::seq_state_t         state_next;
    lmcr_pkg::op_t                op_reg;
    logic [3:0]                   ropc_reg;
    logic [7:0]                   rval_reg;
    logic [lmcr_pkg::ADDR_W-1:0]  pos_reg;
    logic [7:0]                   bit_reg;
    logic                         on_reg;
    logic [2:0]                   f_reg;
    logic [2:0]                   k_reg;
    logic [2:0]                   col_reg;
    logic [2:0]                   drow_reg;

    logic                         accept;
    logic                         in_range;
    logic [9:0]                   pos_full;
    logic [lmcr_pkg::ADDR_W-1:0]  pos;
    logic                         ascending;
    logic                         mirror;
    logic [2:0]                   n_last;
    logic [2:0]                   col_start;
    logic [2:0]                   drow_start;
    logic                         frame_end;
    logic                         final_word;
    logic [9:0]                   run_addr_full;
    logic [3:0]                   run_opcode;

    assign accept = in_valid && (state_reg == lmcr_pkg::ST_IDLE);

    // Pixel range check and byte address
    assign in_range = ({1'b0, pixel_x} < {grid.across[3:0], 3'b000})
                   && ({1'b0, pixel_y} < {grid.down[3:0], 3'b000});
    assign pos_full = 10'(pixel_x[5:3]) + 10'(pixel_y) * 10'(grid.across);
    assign pos      = pos_full[lmcr_pkg::ADDR_W-1:0];

    // Chip order and mirroring from the orientation
    assign ascending = (orientation == lmcr_pkg::ORIENT_UPSIDE_DOWN)
                    || (orientation == lmcr_pkg::ORIENT_TURN_LEFT);
    assign mirror    = (orientation == lmcr_pkg::ORIENT_NORMAL)
                    || (orientation == lmcr_pkg::ORIENT_TURN_LEFT);

    assign n_last     = 3'(grid.count - 4'd1);
    assign col_start  = ascending ? 3'd0 : 3'(grid.across - 4'd1);
    assign drow_start = ascending ? 3'd0 : 3'(grid.down - 4'd1);
    assign frame_end  = (k_reg == n_last);
    assign final_word = frame_end && ((op_reg == lmcr_pkg::OP_BCAST) || (f_reg == 3'd7));

    // Store address of the current chip row: rows run 7 down to 0
    assign run_addr_full = 10'({drow_reg, ~f_reg}) * 10'(grid.across) + 10'(col_reg);

    // Row opcode of the current frame
    always_comb
    begin
        case (op_reg)
            lmcr_pkg::OP_REFRESH: run_opcode = mirror ? 4'({1'b0, f_reg} + 4'd1)
                                                     : 4'(4'd8 - {1'b0, f_reg});
            lmcr_pkg::OP_BCAST:   run_opcode = ropc_reg;
            default:              run_opcode = 4'({1'b0, f_reg} + 4'd1);
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lmcr_pkg::ST_IDLE:
            begin
                if (accept) begin
                    if (operation == lmcr_pkg::OP_SET) begin
                        state_next = in_range ? lmcr_pkg::ST_SET_WR : lmcr_pkg::ST_IDLE;
                    end
                    else begin
                        state_next = lmcr_pkg::ST_RUN;
                    end
                end
            end
            lmcr_pkg::ST_SET_WR: state_next = lmcr_pkg::ST_IDLE;
            lmcr_pkg::ST_RUN:
            begin
                if (adv && final_word) begin
                    state_next = lmcr_pkg::ST_DRAIN;
                end
            end
            lmcr_pkg::ST_DRAIN:
            begin
                if (out_done) begin
                    state_next = lmcr_pkg::ST_IDLE;
                end
            end
            default: state_next = lmcr_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        busy        = 1'b1;
        clear       = 1'b0;
        rd_req.en   = 1'b0;
        rd_req.addr = run_addr_full[lmcr_pkg::ADDR_W-1:0];
        wr_req.en   = 1'b0;
        wr_req.addr = pos_reg;
        wr_req.data = on_reg ? (rd_data | bit_reg) : (rd_data & ~bit_reg);
        issue.valid           = 1'b0;
        issue.meta.use_mem    = (op_reg == lmcr_pkg::OP_REFRESH);
        issue.meta.mirror     = mirror;
        issue.meta.const_byte = (op_reg == lmcr_pkg::OP_BCAST) ? rval_reg : 8'd0;
        issue.meta.opcode     = run_opcode;
        issue.meta.latch      = frame_end;
        issue.meta.last       = final_word;
        case (state_reg)
            lmcr_pkg::ST_IDLE:
            begin
                busy        = 1'b0;
                clear       = accept && (operation == lmcr_pkg::OP_CLEAR);
                rd_req.en   = accept && (operation == lmcr_pkg::OP_SET) && in_range;
                rd_req.addr = pos;
            end
            lmcr_pkg::ST_SET_WR:
            begin
                wr_req.en = 1'b1;
            end
            lmcr_pkg::ST_RUN:
            begin
                issue.valid = 1'b1;
                rd_req.en   = adv && (op_reg == lmcr_pkg::OP_REFRESH);
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Hold the item fields
    always_ff @(posedge clk)
    begin
        if (accept) begin
            ropc_reg <= reg_opcode;
            rval_reg <= reg_value;
            pos_reg  <= pos;
            bit_reg  <= lmcr_pkg::BIT_MSB >> pixel_x[2:0];
            on_reg   <= pixel_on;
        end
    end

    // State, operation and frame/chip counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= lmcr_pkg::ST_IDLE;
            op_reg    <= lmcr_pkg::OP_SET;
            f_reg     <= 3'd0;
            k_reg     <= 3'd0;
            col_reg   <= 3'd0;
            drow_reg  <= 3'd0;
        end
        else begin
            state_reg <= state_next;
            if (accept) begin
                op_reg   <= lmcr_pkg::op_t'(operation);
                f_reg    <= 3'd0;
                k_reg    <= 3'd0;
                col_reg  <= col_start;
                drow_reg <= drow_start;
            end
            else if ((state_reg == lmcr_pkg::ST_RUN) && adv) begin
                if (frame_end) begin
                    // restart the chip walk for the next frame
                    k_reg    <= 3'd0;
                    f_reg    <= f_reg + 3'd1;
                    col_reg  <= col_start;
                    drow_reg <= drow_start;
                end
                else begin
                    k_reg <= k_reg + 3'd1;
                    if (ascending) begin
                        if ({1'b0, col_reg} == 4'(grid.across - 4'd1)) begin
                            col_reg  <= 3'd0;
                            drow_reg <= drow_reg + 3'd1;
                        end
                        else begin
                            col_reg <= col_reg + 3'd1;
                        end
                    end
                    else begin
                        if (col_reg == 3'd0) begin
                            col_reg  <= 3'(grid.across - 4'd1);
                            drow_reg <= drow_reg - 3'd1;
                        end
                        else begin
                            col_reg <= col_reg - 3'd1;
                        end
                    end
                end
            end
        end
    end

endmodule

### rtl/core/led_matrix_chain_refresh_unit.sv
// Top level of the LED matrix chain refresh unit: configuration registers,
// read pipeline and output register. Depends on lmcr_pkg, lmcr_store, lmcr_seq.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_stall) takes one item at a time: set pixel,
//   refresh, broadcast register write or clear. in_stall stays high from the
//   transfer until the item's last word has left the output register.
//   Output channel (out_valid/out_stall) gives device_word, latch and last;
//   latch marks the last word of each chip-select frame, last the item's end.
//   Set pixel: a store read, then a write back; no output word.
//   Refresh, clear: 8*n words, broadcast: n words, where n is the chip count.
//   After the transfer each word passes the read stage, then the output
//   register; words follow one per cycle while the output is not stalled,
//   set by the single read port of the frame store.
//   A stall on the output freezes the read pipeline; no word is lost.
//   Reset clears the frame store at once through per-entry valid bits and sets
//   across = 1, down = 1, orientation = 1. Write configuration (cfg_write,
//   cfg_index, cfg_data) only while the block is idle.
module led_matrix_chain_refresh_unit
#(
    parameter int MAX_DEVICES = lmcr_pkg::MAX_DEVICES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [5:0]  pixel_x,
    input  logic [5:0]  pixel_y,
    input  logic        pixel_on,
    input  logic [3:0]  reg_opcode,
    input  logic [7:0]  reg_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] device_word,
    output logic        latch,
    output logic        last
);

    logic [3:0]           across_reg;
    logic [3:0]           down_reg;
    logic [1:0]           orient_reg;
    lmcr_pkg::grid_t      grid;

    logic                 adv;
    logic                 out_done;
    logic                 busy;
    logic                 clear;
    lmcr_pkg::rd_req_t    rd_req;
    lmcr_pkg::wr_req_t    wr_req;
    lmcr_pkg::issue_t     issue;
    logic [7:0]           rd_data;

    logic                 s1_valid_reg;
    lmcr_pkg::word_meta_t s1_meta_reg;
    logic                 out_valid_reg;
    logic [15:0]          device_word_reg;
    logic                 latch_reg;
    logic                 last_reg;
    logic [7:0]           word_byte;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            across_reg <= 4'd1;
            down_reg   <= 4'd1;
            orient_reg <= lmcr_pkg::ORIENT_UPSIDE_DOWN;
        end
        else if (cfg_write) begin
            case (cfg_index)
                lmcr_pkg::CFG_ACROSS: across_reg <= cfg_data;
                lmcr_pkg::CFG_DOWN:   down_reg   <= cfg_data;
                lmcr_pkg::CFG_ORIENT: orient_reg <= cfg_data[1:0];
                default:              ;
            endcase
        end
    end

    assign grid = lmcr_pkg::grid_size(across_reg, down_reg, 4'(MAX_DEVICES));

    // Pipeline advances when the output register is free or being taken
    assign adv      = !out_valid_reg || !out_stall;
    assign out_done = out_valid_reg && !out_stall && last_reg;

    lmcr_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clear),
        .rd_req  (rd_req),
        .wr_req  (wr_req),
        .rd_data (rd_data)
    );

    lmcr_seq u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .operation   (operation),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_on    (pixel_on),
        .reg_opcode  (reg_opcode),
        .reg_value   (reg_value),
        .grid        (grid),
        .orientation (orient_reg),
        .adv         (adv),
        .out_done    (out_done),
        .rd_data     (rd_data),
        .busy        (busy),
        .clear       (clear),
        .rd_req      (rd_req),
        .wr_req      (wr_req),
        .issue       (issue)
    );

    assign in_stall = busy;

    // Form the data byte from the store read or the constant
    always_comb
    begin
        if (s1_meta_reg.use_mem) begin
            word_byte = s1_meta_reg.mirror ? lmcr_pkg::mirror8(rd_data) : rd_data;
        end
        else begin
            word_byte = s1_meta_reg.const_byte;
        end
    end

    // Advance valid flags of the read stage and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv) begin
            s1_valid_reg  <= issue.valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Advance payloads
    always_ff @(posedge clk)
    begin
        if (adv) begin
            s1_meta_reg <= issue.meta;
            if (s1_valid_reg) begin
                device_word_reg <= {4'd0, s1_meta_reg.opcode, word_byte};
                latch_reg       <= s1_meta_reg.latch;
                last_reg        <= s1_meta_reg.last;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign device_word = device_word_reg;
    assign latch       = latch_reg;
    assign last        = last_reg;

`ifndef ASSERT_OFF
    // Idle only with an empty read pipeline
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> (!out_valid_reg && !s1_valid_reg))
        else $error("input taken while words are still in flight");

    // The final word of an item releases the input side
    a_last_release: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last) |=> !in_stall)
        else $error("input not released after final word");

    // The final word always closes a frame
    a_last_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> latch)
        else $error("final word without latch");

    // No store write while a word read is in flight
    a_no_write_run: assert property (@(posedge clk) disable iff (!rst_n)
        wr_req.en |-> (!s1_valid_reg && !issue.valid))
        else $error("store write during word sequence");
`endif

endmodule
